// File: sv/md5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables of the MD5 hash engine.
// ----------------------------------------------------------------------------
package md5_pkg;

	localparam int CNT_W = 61;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hefcdab89;
	localparam logic [31:0] IV2 = 32'h98badcfe;
	localparam logic [31:0] IV3 = 32'h10325476;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LAST_POS = 6'h3f;
	localparam logic [5:0] LEN_POS  = 6'd56;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       load_byte; // write one message byte, bump the count
		logic       pad;       // pad the tail of the current block
		logic       len_blk;   // zero the block and place the length
		logic       start;     // load working words from the chain value
		logic       round_en;  // run one compression round
		logic       fold;      // add working words into the chain value
		logic       restart;   // back to initial chain value and zero count
		logic [1:0] word_sel;  // digest word on the output
	} md5_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic pos_last;   // next byte completes the block
		logic pos_hi;     // tail leaves no room for the length
		logic round_last; // current round is the 64th
	} md5_sts_t;

	localparam logic [31:0] RND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam logic [4:0] ROT_S [16] = '{
		5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
		5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
	};

	// Rotate left by a variable amount
	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] t;
		t = {v, v} << s;
		return t[63:32];
	endfunction

endpackage

// File: sv/md5_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer: request intake, compression passes, padding and digest output.
// ----------------------------------------------------------------------------
module md5_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              kind,
	input  md5_pkg::md5_sts_t sts,
	input  logic              out_free,
	output logic              item_stall,
	output logic              push,
	output md5_pkg::md5_cmd_t cmd
);
	import md5_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RUN  = 3'd1;
	localparam logic [2:0] ST_FIN  = 3'd2;
	localparam logic [2:0] ST_LEN  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q, state_d;
	logic       final_q, final_d;   // pass belongs to an end request
	logic       second_q, second_d; // a length-only block still follows
	logic [1:0] word_q, word_d;
	logic       accept;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		final_d  = final_q;
		second_d = second_q;
		word_d   = word_q;
		cmd      = '0;
		push     = 1'b0;
		cmd.word_sel = word_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!kind) begin
						cmd.load_byte = 1'b1;
						if (sts.pos_last) begin
							cmd.start = 1'b1;
							final_d   = 1'b0;
							state_d   = ST_RUN;
						end
					end else begin
						cmd.pad   = 1'b1;
						cmd.start = 1'b1;
						final_d   = 1'b1;
						second_d  = sts.pos_hi;
						state_d   = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				cmd.round_en = 1'b1;
				if (sts.round_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.fold = 1'b1;
				if (!final_q) begin
					state_d = ST_IDLE;
				end else if (second_q) begin
					second_d = 1'b0;
					state_d  = ST_LEN;
				end else begin
					word_d  = '0;
					state_d = ST_EMIT;
				end
			end
			ST_LEN: begin
				cmd.len_blk = 1'b1;
				cmd.start   = 1'b1;
				state_d     = ST_RUN;
			end
			ST_EMIT: begin
				if (out_free) begin
					push   = 1'b1;
					word_d = word_q + 2'd1;
					if (word_q == 2'd3) begin
						cmd.restart = 1'b1;
						state_d     = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			final_q  <= 1'b0;
			second_q <= 1'b0;
			word_q   <= '0;
		end else begin
			state_q  <= state_d;
			final_q  <= final_d;
			second_q <= second_d;
			word_q   <= word_d;
		end
	end

endmodule

// File: sv/md5_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_dp
// Datapath: message block, byte count, chain value and the MD5 round unit.
// ----------------------------------------------------------------------------
module md5_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  md5_pkg::md5_cmd_t cmd,
	input  logic [7:0]        data_byte,
	output md5_pkg::md5_sts_t sts,
	output logic [31:0]       digest
);
	import md5_pkg::*;

	logic [31:0]      blk_q [16];
	logic [31:0]      chain_q [4];
	logic [CNT_W-1:0] count_q;
	logic [31:0]      a_q, b_q, c_q, d_q;
	logic [5:0]       rnd_q;

	logic [5:0]  pos;
	logic [63:0] bitlen;
	logic [1:0]  quarter;
	logic [3:0]  idx;
	logic [3:0]  g;
	logic [31:0] f;
	logic [31:0] sum;
	logic [31:0] b_new;

	assign pos    = count_q[5:0];
	assign bitlen = {count_q, 3'b000};

	assign sts.pos_last   = (pos == LAST_POS);
	assign sts.pos_hi     = (pos >= LEN_POS);
	assign sts.round_last = (rnd_q == 6'd63);

	assign digest = chain_q[cmd.word_sel];

	// Round function and message word select
	assign quarter = rnd_q[5:4];
	assign idx     = rnd_q[3:0];
	always_comb begin
		case (quarter)
			2'd0: begin
				f = d_q ^ (b_q & (c_q ^ d_q));
				g = idx;
			end
			2'd1: begin
				f = c_q ^ (d_q & (b_q ^ c_q));
				g = 4'((idx << 2) + idx + 4'd1);
			end
			2'd2: begin
				f = b_q ^ c_q ^ d_q;
				g = 4'((idx << 1) + idx + 4'd5);
			end
			default: begin
				f = c_q ^ (b_q | ~d_q);
				g = 4'((idx << 3) - idx);
			end
		endcase
	end

	assign sum   = a_q + f + RND_K[rnd_q] + blk_q[g];
	assign b_new = b_q + rotl(sum, ROT_S[{quarter, rnd_q[1:0]}]);

	// Message block: byte writes, tail padding, length block
	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			blk_q[pos[5:2]][pos[1:0]*8 +: 8] <= data_byte;
		end
		if (cmd.pad) begin
			for (int w = 0; w < 16; w++) begin
				for (int b = 0; b < 4; b++) begin
					if (6'(w * 4 + b) == pos) begin
						blk_q[w][b*8 +: 8] <= PAD_BYTE;
					end else if (6'(w * 4 + b) > pos) begin
						blk_q[w][b*8 +: 8] <= 8'h00;
					end
				end
			end
			if (!sts.pos_hi) begin
				blk_q[14] <= bitlen[31:0];
				blk_q[15] <= bitlen[63:32];
			end
		end
		if (cmd.len_blk) begin
			for (int w = 0; w < 14; w++) begin
				blk_q[w] <= '0;
			end
			blk_q[14] <= bitlen[31:0];
			blk_q[15] <= bitlen[63:32];
		end
	end

	// Working words: load from the chain, then advance one round a cycle
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (cmd.round_en) begin
			a_q <= d_q;
			b_q <= b_new;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	// Round counter, byte count and chain value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q      <= '0;
			count_q    <= '0;
			chain_q[0] <= IV0;
			chain_q[1] <= IV1;
			chain_q[2] <= IV2;
			chain_q[3] <= IV3;
		end else begin
			if (cmd.start) begin
				rnd_q <= '0;
			end else if (cmd.round_en) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (cmd.restart) begin
				count_q    <= '0;
				chain_q[0] <= IV0;
				chain_q[1] <= IV1;
				chain_q[2] <= IV2;
				chain_q[3] <= IV3;
			end else begin
				if (cmd.load_byte) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (cmd.fold) begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
				end
			end
		end
	end

endmodule

// File: sv/md5_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_hash_engine
// MD5 digest over a byte stream, one compression round per cycle.
// ----------------------------------------------------------------------------
// Request channel (item_valid / item_stall, kind, data_byte): kind 0 carries
// one message byte, kind 1 ends the message and asks for the digest.
// Digest channel (digest_valid / digest_stall): four requests per end of
// message, word_index 0..3, last_word on the fourth, bytes little-endian.
// The 64th byte of a block starts a compression of 64 rounds and a fold into
// the chain value, run one after the other on the single round unit; no byte
// is taken until the fold is done.
// An end request pads in its accept cycle and then compresses; a tail of 56
// or more bytes adds a second length block, compressed after the first. The
// first digest word follows the last fold, the others follow one per cycle
// while the digest side does not stall; the engine then takes new bytes again.
// The digest words leave through an output register: a stall there holds the
// current word and pauses the digest sequence; bytes are not accepted until
// all four words are registered.
// Reset returns the initial chain value and a zero byte count at once.
// ----------------------------------------------------------------------------
module md5_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        kind,
	input  logic [7:0]  data_byte,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);
	import md5_pkg::*;

	md5_cmd_t    cmd;
	md5_sts_t    sts;
	logic        push;
	logic        out_free;
	logic [31:0] digest;
	logic        dvalid_q;
	logic [31:0] dword_q;
	logic [1:0]  didx_q;
	logic        dlast_q;

	assign out_free = !dvalid_q || !digest_stall;

	md5_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.kind       (kind),
		.sts        (sts),
		.out_free   (out_free),
		.item_stall (item_stall),
		.push       (push),
		.cmd        (cmd)
	);

	md5_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (data_byte),
		.sts       (sts),
		.digest    (digest)
	);

	// Output register: load a digest word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_q <= 1'b0;
		end else if (push) begin
			dvalid_q <= 1'b1;
		end else if (!digest_stall) begin
			dvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			dword_q <= digest;
			didx_q  <= cmd.word_sel;
			dlast_q <= (cmd.word_sel == 2'd3);
		end
	end

	assign digest_valid = dvalid_q;
	assign digest_word  = dword_q;
	assign word_index   = didx_q;
	assign last_word    = dlast_q;

endmodule

// File: dv/md5_hash_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_hash_engine_tb
// Self-checking bench for the MD5 byte-stream hash engine. Messages are fed
// one byte per request and closed by an end request. An in-bench MD5 model
// computes the expected digest words. Each digest request is checked field
// by field against them. Both channels idle and stall at random, with one
// long digest hold-off and one full drain pause.
// ----------------------------------------------------------------------------
module md5_hash_engine_tb;

	import md5_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 150;
	localparam int ITEM_GOAL   = 450;
	localparam int IDLE_PCT    = 17;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Content patterns for generated messages
	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZERO   = 1;
	localparam int FILL_ONES   = 2;

	localparam logic [31:0] ROUND_ADD [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int SHIFT_TAB [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	localparam logic [31:0] CHAIN_INIT [4] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
	};

	typedef struct {
		logic [31:0] word;
		logic [1:0]  index;
		logic        last;
	} digest_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	logic        kind         = KIND_BYTE;
	logic [7:0]  data_byte    = 8'h00;
	logic        digest_valid;
	logic        digest_stall = 1'b0;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	// Hash model state
	logic [31:0] hash_chain [4];
	logic [31:0] hash_block [16];
	logic [60:0] hash_count;

	digest_t digest_expected [$];

	int errors        = 0;
	int items_sent    = 0;
	int messages_sent = 0;
	int words_checked = 0;
	int hold_token    = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	bit no_idle       = 1'b0;

	md5_hash_engine DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Hash model
	// ------------------------------------------------------------------
	function automatic void hash_reset_chain();
		for (int k = 0; k < 4; k++)
			hash_chain[k] = CHAIN_INIT[k];
		hash_count = '0;
	endfunction

	function automatic void hash_put_byte(input int pos, input logic [7:0] v);
		hash_block[pos / 4][(pos % 4) * 8 +: 8] = v;
	endfunction

	// Run the 64 rounds over the current block and fold into the chain
	function automatic void hash_compress();
		logic [31:0] a, b, c, d, f, sum, t;
		int g, s, q;
		a = hash_chain[0];
		b = hash_chain[1];
		c = hash_chain[2];
		d = hash_chain[3];
		for (int i = 0; i < 64; i++) begin
			q = i / 16;
			case (q)
				0: begin
					f = d ^ (b & (c ^ d));
					g = i;
				end
				1: begin
					f = c ^ (d & (b ^ c));
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			s = SHIFT_TAB[q * 4 + i % 4];
			sum = a + f + ROUND_ADD[i] + hash_block[g];
			t = d;
			d = c;
			c = b;
			b = b + ((sum << s) | (sum >> (32 - s)));
			a = t;
		end
		hash_chain[0] += a;
		hash_chain[1] += b;
		hash_chain[2] += c;
		hash_chain[3] += d;
	endfunction

	// Absorb one accepted request; an end request queues four digest words
	function automatic void hash_absorb(input logic k, input logic [7:0] v);
		int pos;
		logic [63:0] bit_len;
		digest_t dw;
		pos = int'(hash_count[5:0]);
		if (k == KIND_BYTE) begin
			hash_put_byte(pos, v);
			hash_count = hash_count + 61'd1;
			if (pos == 63)
				hash_compress();
		end else begin
			hash_put_byte(pos, 8'h80);
			for (int p = pos + 1; p < 64; p++)
				hash_put_byte(p, 8'h00);
			// Tail leaves no room for the length: spill into a second block
			if (pos >= 56) begin
				hash_compress();
				for (int w = 0; w < 16; w++)
					hash_block[w] = 32'h0;
			end
			bit_len = {hash_count, 3'b000};
			hash_block[14] = bit_len[31:0];
			hash_block[15] = bit_len[63:32];
			hash_compress();
			for (int w = 0; w < 4; w++) begin
				dw.word  = hash_chain[w];
				dw.index = 2'(w);
				dw.last  = (w == 3);
				digest_expected.push_back(dw);
			end
			hash_reset_chain();
		end
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------
	task automatic send_request(input logic k, input logic [7:0] v);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind       <= k;
		data_byte  <= v;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		hash_absorb(k, v);
		items_sent++;
		if (k == KIND_END)
			messages_sent++;
	endtask

	task automatic send_message(input int len, input int fill);
		logic [7:0] v;
		for (int n = 0; n < len; n++) begin
			case (fill)
				FILL_ZERO: v = 8'h00;
				FILL_ONES: v = 8'hff;
				default:   v = 8'($urandom_range(255));
			endcase
			send_request(KIND_BYTE, v);
		end
		// The data byte of an end request is ignored; keep it random
		send_request(KIND_END, 8'($urandom_range(255)));
	endtask

	task automatic wait_drained();
		while (digest_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic park_request();
		item_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Digest side: check accepted words, drive stall
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h (word %0d)", what, got, want,
			words_checked);
		errors++;
	endtask

	task automatic check_digest();
		digest_t dw;
		if (digest_expected.size() == 0) begin
			report_mismatch("digest_word, none expected", digest_word, 32'h0);
		end else begin
			dw = digest_expected.pop_front();
			if (digest_word !== dw.word)
				report_mismatch("digest_word", digest_word, dw.word);
			if (word_index !== dw.index)
				report_mismatch("word_index", 32'(word_index), 32'(dw.index));
			if (last_word !== dw.last)
				report_mismatch("last_word", 32'(last_word), 32'(dw.last));
		end
		words_checked++;
	endtask

	always @(posedge clk) begin
		if (arst_n && digest_valid === 1'b1 && !digest_stall)
			check_digest();
		// Start a long hold-off when the test asks for one
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			digest_stall <= 1'b1;
			hold_left--;
		end else if (no_idle) begin
			digest_stall <= 1'b0;
		end else begin
			digest_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Stop the run when nothing moves on either channel for too long
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (digest_valid === 1'b1 && !digest_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_empty_message();
		send_request(KIND_END, 8'hff);
	endtask

	task automatic test_short_messages();
		send_request(KIND_BYTE, 8'h61);
		send_request(KIND_BYTE, 8'h62);
		send_request(KIND_BYTE, 8'h63);
		send_request(KIND_END, 8'h00);
		send_request(KIND_BYTE, 8'h00);
		send_request(KIND_END, 8'hff);
		send_request(KIND_BYTE, 8'hff);
		send_request(KIND_END, 8'h00);
		send_request(KIND_END, 8'h5a);
	endtask

	// Tail lengths around the point where the length spills to a new block
	task automatic test_tail_lengths();
		send_message(55, FILL_RANDOM);
		send_message(56, FILL_ZERO);
		send_message(63, FILL_ONES);
		send_message(64, FILL_RANDOM);
	endtask

	// Hold the digest side while the sender keeps offering bytes
	task automatic test_backpressure();
		hold_token <= hold_token + 1;
		send_message(5, FILL_RANDOM);
		send_message(9, FILL_RANDOM);
		send_message(2, FILL_RANDOM);
	endtask

	task automatic test_drain_pause();
		park_request();
		wait_drained();
		send_message(12, FILL_RANDOM);
	endtask

	task automatic test_no_idle();
		no_idle <= 1'b1;
		send_message(70, FILL_RANDOM);
		send_message(3, FILL_RANDOM);
		send_message(0, FILL_RANDOM);
		no_idle <= 1'b0;
	endtask

	// Mostly short messages, some near block edges, a few past two blocks
	task automatic test_random_messages();
		int pick;
		int len;
		while (items_sent < ITEM_GOAL) begin
			pick = $urandom_range(99);
			if (pick < 65)
				len = $urandom_range(0, 20);
			else if (pick < 90)
				len = $urandom_range(50, 70);
			else
				len = $urandom_range(0, 130);
			send_message(len, FILL_RANDOM);
		end
	endtask

	initial begin
		hash_reset_chain();
		for (int w = 0; w < 16; w++)
			hash_block[w] = 32'h0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_message();
		test_short_messages();
		test_tail_lengths();
		test_backpressure();
		test_drain_pause();
		test_no_idle();
		test_random_messages();

		park_request();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d requests in %0d messages, %0d digest words checked",
			items_sent, messages_sent, words_checked);
		$display("incl. empty and spill-over tails, digest hold-off and drain pause");
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: md5_hash_engine.f
sv/md5_pkg.sv
sv/md5_ctrl.sv
sv/md5_dp.sv
sv/md5_hash_engine.sv
dv/md5_hash_engine_tb.sv
